/* rtl/gzhp_pkg.sv */
// Package with payload types, phase codes and constants of the gzip header parser.
package gzhp_pkg;

    localparam int unsigned LEN_BITS_DEF = 16;

    localparam logic [3:0] PH_ID1     = 4'd0;
    localparam logic [3:0] PH_ID2     = 4'd1;
    localparam logic [3:0] PH_CM      = 4'd2;
    localparam logic [3:0] PH_FLG     = 4'd3;
    localparam logic [3:0] PH_MTIME   = 4'd4;
    localparam logic [3:0] PH_XFL     = 4'd5;
    localparam logic [3:0] PH_OS      = 4'd6;
    localparam logic [3:0] PH_XLEN    = 4'd7;
    localparam logic [3:0] PH_EXTRA   = 4'd8;
    localparam logic [3:0] PH_NAME    = 4'd9;
    localparam logic [3:0] PH_COMMENT = 4'd10;
    localparam logic [3:0] PH_HCRC    = 4'd11;
    localparam logic [3:0] PH_PAYLOAD = 4'd12;
    localparam logic [3:0] PH_ERROR   = 4'd13;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_SIG       = 3'd1;
    localparam logic [2:0] ERR_METHOD    = 3'd2;
    localparam logic [2:0] ERR_NAME      = 3'd3;
    localparam logic [2:0] ERR_COMMENT   = 3'd4;
    localparam logic [2:0] ERR_TRUNCATED = 3'd5;

    localparam logic [7:0] ID1_BYTE  = 8'h1f;
    localparam logic [7:0] ID2_BYTE  = 8'h8b;
    localparam logic [7:0] CM_DEFL   = 8'h08;
    localparam logic [7:0] ZERO_BYTE = 8'h00;

    localparam int unsigned FL_HCRC    = 1;
    localparam int unsigned FL_EXTRA   = 2;
    localparam int unsigned FL_NAME    = 3;
    localparam int unsigned FL_COMMENT = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       member_start;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  byte_kind;
        logic [2:0]  error_code;
        logic [7:0]  header_flags;
        logic [31:0] mtime_secs;
        logic [7:0]  extra_flags;
        logic [7:0]  os_code;
        logic [15:0] extra_len;
        logic [15:0] name_len;
        logic [15:0] header_crc;
        logic [15:0] header_len;
    } t_out_item;

    // Classified item passed from the front part to the back part.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       member_start;
        logic       end_of_input;
        logic       is_zero;
        logic       is_id1;
        logic       is_id2;
        logic       is_cm;
    } t_cls_item;

endpackage

/* rtl/gzhp_front.sv */
// Front part: accepts input items, classifies the byte and writes a two-entry queue.
module gzhp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  gzhp_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output gzhp_pkg::t_cls_item o_item
);
    gzhp_pkg::t_cls_item r_q [2];
    gzhp_pkg::t_cls_item n_cls;
    logic                r_rd_ptr, r_wr_ptr;
    logic [1:0]          r_cnt;
    logic                push, pop;

    always_comb begin
        n_cls.data_byte    = i_item.data_byte;
        n_cls.member_start = i_item.member_start;
        n_cls.end_of_input = i_item.end_of_input;
        n_cls.is_zero      = (i_item.data_byte == gzhp_pkg::ZERO_BYTE);
        n_cls.is_id1       = (i_item.data_byte == gzhp_pkg::ID1_BYTE);
        n_cls.is_id2       = (i_item.data_byte == gzhp_pkg::ID2_BYTE);
        n_cls.is_cm        = (i_item.data_byte == gzhp_pkg::CM_DEFL);
    end

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= n_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= 1'b0;
            r_wr_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (pop) r_rd_ptr <= ~r_rd_ptr;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

/* rtl/gzhp_back.sv */
// Back part: header state machine, field capture and the registered result.
module gzhp_back #(
    parameter int unsigned LEN_BITS = gzhp_pkg::LEN_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  gzhp_pkg::t_cls_item i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output gzhp_pkg::t_out_item o_item
);
    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    logic [3:0]          r_phase, n_phase, ph;
    logic [15:0]         r_fcnt, n_fcnt, fcnt;
    logic [7:0]          r_flags, n_flags, flags;
    logic [31:0]         r_mtime, n_mtime, mtime;
    logic [7:0]          r_xfl, n_xfl, xfl;
    logic [7:0]          r_os, n_os, os;
    logic [15:0]         r_xlen, n_xlen, xlen;
    logic [LEN_BITS-1:0] r_ncnt, n_ncnt, ncnt;
    logic [15:0]         r_hcrc, n_hcrc, hcrc;
    logic [LEN_BITS-1:0] r_hcnt, n_hcnt, hcnt;
    logic [2:0]          r_err, n_err, err;
    logic                hdr;
    logic [3:0]          aft_extra, aft_name, aft_comment;
    logic [15:0]         xlen_full;
    gzhp_pkg::t_out_item n_out, r_out;
    logic                r_out_valid, take;

    assign o_ready = !r_out_valid || i_ready;
    assign take    = i_valid && o_ready;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    always_comb begin
        // A member start clears everything before the byte is looked at.
        if (i_item.member_start) begin
            ph = gzhp_pkg::PH_ID1; fcnt = '0; flags = '0; mtime = '0; xfl = '0;
            os = '0; xlen = '0; ncnt = '0; hcrc = '0; hcnt = '0;
            err = gzhp_pkg::ERR_NONE;
        end else begin
            ph = r_phase; fcnt = r_fcnt; flags = r_flags; mtime = r_mtime; xfl = r_xfl;
            os = r_os; xlen = r_xlen; ncnt = r_ncnt; hcrc = r_hcrc; hcnt = r_hcnt;
            err = r_err;
        end
        n_phase = ph; n_fcnt = fcnt; n_flags = flags; n_mtime = mtime; n_xfl = xfl;
        n_os = os; n_xlen = xlen; n_ncnt = ncnt; n_hcrc = hcrc; n_hcnt = hcnt;
        n_err = err;
        hdr = 1'b0;
        xlen_full = {i_item.data_byte, xlen[7:0]};

        priority if (flags[gzhp_pkg::FL_NAME]) aft_extra = gzhp_pkg::PH_NAME;
        else if (flags[gzhp_pkg::FL_COMMENT]) aft_extra = gzhp_pkg::PH_COMMENT;
        else if (flags[gzhp_pkg::FL_HCRC]) aft_extra = gzhp_pkg::PH_HCRC;
        else aft_extra = gzhp_pkg::PH_PAYLOAD;
        priority if (flags[gzhp_pkg::FL_COMMENT]) aft_name = gzhp_pkg::PH_COMMENT;
        else if (flags[gzhp_pkg::FL_HCRC]) aft_name = gzhp_pkg::PH_HCRC;
        else aft_name = gzhp_pkg::PH_PAYLOAD;
        aft_comment = flags[gzhp_pkg::FL_HCRC] ? gzhp_pkg::PH_HCRC : gzhp_pkg::PH_PAYLOAD;

        unique case (ph)
            gzhp_pkg::PH_ID1: begin
                if (i_item.is_id1) begin
                    hdr = 1'b1; n_phase = gzhp_pkg::PH_ID2;
                end else begin
                    n_phase = gzhp_pkg::PH_ERROR; n_err = gzhp_pkg::ERR_SIG;
                end
            end
            gzhp_pkg::PH_ID2: begin
                if (i_item.is_id2) begin
                    hdr = 1'b1; n_phase = gzhp_pkg::PH_CM;
                end else begin
                    n_phase = gzhp_pkg::PH_ERROR; n_err = gzhp_pkg::ERR_SIG;
                end
            end
            gzhp_pkg::PH_CM: begin
                if (i_item.is_cm) begin
                    hdr = 1'b1; n_phase = gzhp_pkg::PH_FLG;
                end else begin
                    n_phase = gzhp_pkg::PH_ERROR; n_err = gzhp_pkg::ERR_METHOD;
                end
            end
            gzhp_pkg::PH_FLG: begin
                hdr = 1'b1; n_flags = i_item.data_byte; n_fcnt = '0;
                n_phase = gzhp_pkg::PH_MTIME;
            end
            gzhp_pkg::PH_MTIME: begin
                hdr = 1'b1;
                unique case (fcnt[1:0])
                    2'd0: n_mtime[7:0]   = mtime[7:0]   | i_item.data_byte;
                    2'd1: n_mtime[15:8]  = mtime[15:8]  | i_item.data_byte;
                    2'd2: n_mtime[23:16] = mtime[23:16] | i_item.data_byte;
                    default: n_mtime[31:24] = mtime[31:24] | i_item.data_byte;
                endcase
                if (fcnt >= 16'd3) begin
                    n_fcnt = '0; n_phase = gzhp_pkg::PH_XFL;
                end else begin
                    n_fcnt = fcnt + 16'd1;
                end
            end
            gzhp_pkg::PH_XFL: begin
                hdr = 1'b1; n_xfl = i_item.data_byte; n_phase = gzhp_pkg::PH_OS;
            end
            gzhp_pkg::PH_OS: begin
                hdr = 1'b1; n_os = i_item.data_byte; n_fcnt = '0;
                n_phase = flags[gzhp_pkg::FL_EXTRA] ? gzhp_pkg::PH_XLEN : aft_extra;
            end
            gzhp_pkg::PH_XLEN: begin
                hdr = 1'b1;
                if (fcnt == 16'd0) begin
                    n_xlen = {8'd0, i_item.data_byte}; n_fcnt = 16'd1;
                end else begin
                    n_xlen = xlen_full; n_fcnt = xlen_full;
                    n_phase = (xlen_full == 16'd0) ? aft_extra : gzhp_pkg::PH_EXTRA;
                end
            end
            gzhp_pkg::PH_EXTRA: begin
                hdr = 1'b1; n_fcnt = fcnt - 16'd1;
                if (fcnt == 16'd1) n_phase = aft_extra;
            end
            gzhp_pkg::PH_NAME: begin
                hdr = 1'b1;
                if (i_item.is_zero) n_phase = aft_name;
                else if (ncnt != LEN_MAX) n_ncnt = ncnt + 1'b1;
            end
            gzhp_pkg::PH_COMMENT: begin
                hdr = 1'b1;
                if (i_item.is_zero) n_phase = aft_comment;
            end
            gzhp_pkg::PH_HCRC: begin
                hdr = 1'b1;
                if (fcnt == 16'd0) begin
                    n_hcrc = {8'd0, i_item.data_byte}; n_fcnt = 16'd1;
                end else begin
                    n_hcrc = {i_item.data_byte, hcrc[7:0]}; n_fcnt = '0;
                    n_phase = gzhp_pkg::PH_PAYLOAD;
                end
            end
            gzhp_pkg::PH_PAYLOAD: ;
            gzhp_pkg::PH_ERROR: ;
            default: n_phase = gzhp_pkg::PH_ERROR;
        endcase

        if (hdr) begin
            if (hcnt != LEN_MAX) n_hcnt = hcnt + 1'b1;
            if (i_item.end_of_input && n_phase != gzhp_pkg::PH_PAYLOAD) begin
                priority if (n_phase == gzhp_pkg::PH_NAME) n_err = gzhp_pkg::ERR_NAME;
                else if (n_phase == gzhp_pkg::PH_COMMENT) n_err = gzhp_pkg::ERR_COMMENT;
                else n_err = gzhp_pkg::ERR_TRUNCATED;
                n_phase = gzhp_pkg::PH_ERROR;
            end
        end

        priority if (n_phase == gzhp_pkg::PH_ERROR) n_out.byte_kind = gzhp_pkg::KIND_ERROR;
        else if (hdr) n_out.byte_kind = gzhp_pkg::KIND_HEADER;
        else n_out.byte_kind = gzhp_pkg::KIND_PAYLOAD;
        n_out.error_code   = n_err;
        n_out.header_flags = n_flags;
        n_out.mtime_secs   = n_mtime;
        n_out.extra_flags  = n_xfl;
        n_out.os_code      = n_os;
        n_out.extra_len    = n_xlen;
        n_out.header_crc   = n_hcrc;
        n_out.name_len     = 16'(n_ncnt);
        n_out.header_len   = 16'(n_hcnt);
    end

    always_ff @(posedge i_clk) begin
        if (take) r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= gzhp_pkg::PH_ID1; r_fcnt <= '0; r_flags <= '0; r_mtime <= '0;
            r_xfl <= '0; r_os <= '0; r_xlen <= '0; r_ncnt <= '0; r_hcrc <= '0;
            r_hcnt <= '0; r_err <= gzhp_pkg::ERR_NONE; r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_phase <= n_phase; r_fcnt <= n_fcnt; r_flags <= n_flags;
                r_mtime <= n_mtime; r_xfl <= n_xfl; r_os <= n_os; r_xlen <= n_xlen;
                r_ncnt <= n_ncnt; r_hcrc <= n_hcrc; r_hcnt <= n_hcnt; r_err <= n_err;
            end
            if (take) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end
endmodule

/* rtl/gzip_member_header_parser.sv */
// An accepted input item is written to the queue, and its result is then registered in the
// result register.
// Throughput: one byte per cycle unless the output stalls; the header state machine is combinational.
// A two-entry queue parts classification from the state machine so each side stalls alone.
// Reset (synchronous, active low) empties the queue and result register and sets the
// parser to expect the first signature byte with all captured fields zero.
module gzip_member_header_parser #(
    parameter int unsigned LEN_BITS = gzhp_pkg::LEN_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  gzhp_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output gzhp_pkg::t_out_item o_data
);
    gzhp_pkg::t_cls_item q_item;
    logic                q_valid, q_ready;

    gzhp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_item(i_data),
        .o_valid(q_valid), .i_ready(q_ready), .o_item(q_item)
    );

    gzhp_back #(.LEN_BITS(LEN_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_item(q_item),
        .o_valid(o_valid), .i_ready(i_ready), .o_item(o_data)
    );
endmodule

/* rtl/gzhp_checker.sv */
// Port-level checker for the gzip header parser, bound to the top level.
module gzhp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input gzhp_pkg::t_in_item  i_data,
    input logic                o_valid,
    input logic                i_ready,
    input gzhp_pkg::t_out_item o_data
);
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_data))
        else $error("input item changed while waiting");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result item changed while stalled");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.byte_kind != 2'd3)
        else $error("byte kind out of range");

    a_err_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.byte_kind != gzhp_pkg::KIND_ERROR
        |-> o_data.error_code == gzhp_pkg::ERR_NONE)
        else $error("error code without error kind");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");
endmodule

bind gzip_member_header_parser gzhp_checker u_gzhp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
);
